@@ src/rqle_pkg.sv @@
// ----------------------------------------------------------------------------
// rqle_pkg: shared types and constants of the register query link engine
// Operation, result and status codes, frame constants and the command record
// that the front end hands to the back end.
// ----------------------------------------------------------------------------
package rqle_pkg;

   // operation codes on the request side
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_RX    = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_TX   = 2'd0,
      KIND_ECHO = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   // finish status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_CHECK = 2'd1,
      ST_NAK       = 2'd2,
      ST_TIMEOUT   = 2'd3
   } status_type;

   // command forms carried through the queue
   typedef enum logic [1:0] {
      FORM_QUERY = 2'd0,
      FORM_ECHO  = 2'd1,
      FORM_DONE  = 2'd2
   } form_type;

   // configuration register indexes (paddr bit 2)
   localparam logic REG_MODE    = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   // frame bytes
   localparam logic [7:0] HDR_S      = 8'h02;
   localparam logic [7:0] HDR_I      = 8'h03;
   localparam logic [7:0] CMD_I      = 8'h40;
   localparam logic [7:0] NAK_FIRST  = 8'h15;
   localparam logic [7:0] NAK_SECOND = 8'hEA;
   localparam logic [7:0] REG_SHORT6 = 8'h50;
   localparam logic [7:0] REG_SHORT4 = 8'h56;

   // reply lengths
   localparam logic [8:0] LEN_I      = 9'd12;
   localparam logic [8:0] LEN_S_LONG = 9'd18;
   localparam logic [8:0] LEN_S_6    = 9'd6;
   localparam logic [8:0] LEN_S_4    = 9'd4;

   // command queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   typedef struct packed {
      form_type   form;
      logic       mode_i;
      logic [7:0] reg_id;
      logic [7:0] rx_byte;
      logic [8:0] rx_index;
      logic       has_done;
      status_type status;
      logic [8:0] count;
      logic [7:0] check;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [8:0] byte_index;
      status_type status;
      logic [8:0] received_count;
      logic [7:0] computed_check;
      logic       last;
   } rsp_type;

endpackage

@@ src/rqle_front.sv @@
// ----------------------------------------------------------------------------
// rqle_front: request intake and query state
// Takes one request per cycle while the command queue has room, updates the
// query state and pushes a command for every request that yields results.
// ----------------------------------------------------------------------------
module rqle_front import rqle_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // operation
   input  logic [15:0] req_tdata,   // register_id [7:0], rx_byte [15:8]
   input  logic        protocol_mode,
   input  logic [15:0] timeout_ticks,
   input  qstat_type   qstat,
   output logic        push,
   output cmd_type     push_cmd
);

   logic       busy_ff,     busy_in;
   logic [8:0] rx_count_ff, rx_count_in;
   logic [8:0] exp_len_ff,  exp_len_in;
   logic [7:0] sum_ff,      sum_in;
   logic [7:0] first_ff,    first_in;
   logic [15:0] ticks_ff,   ticks_in;

   logic        accept;
   op_type      op;
   logic [7:0]  reg_id;
   logic [7:0]  rx;
   logic [8:0]  cnt_next;
   logic [8:0]  exp_eff;
   logic [7:0]  chk;
   logic [15:0] ticks_next;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign reg_id     = req_tdata[7:0];
   assign rx         = req_tdata[15:8];
   assign cnt_next   = rx_count_ff + 9'd1;
   assign exp_eff    = (protocol_mode && cnt_next == 9'd3) ? ({1'b0, rx} + 9'd2) : exp_len_ff;
   assign chk        = ~sum_ff;
   assign ticks_next = (ticks_ff != 16'hFFFF) ? ticks_ff + 16'd1 : ticks_ff;

   always_comb begin
      busy_in     = busy_ff;
      rx_count_in = rx_count_ff;
      exp_len_in  = exp_len_ff;
      sum_in      = sum_ff;
      first_in    = first_ff;
      ticks_in    = ticks_ff;
      push        = 1'b0;
      push_cmd    = '0;
      push_cmd.mode_i   = protocol_mode;
      push_cmd.reg_id   = reg_id;
      push_cmd.rx_byte  = rx;
      push_cmd.rx_index = rx_count_ff;
      push_cmd.count    = cnt_next;
      if (accept) begin
         case (op)
            OP_START: begin
               push          = 1'b1;
               push_cmd.form = FORM_QUERY;
               busy_in       = 1'b1;
               rx_count_in   = '0;
               sum_in        = '0;
               first_in      = '0;
               ticks_in      = '0;
               if (protocol_mode) begin
                  exp_len_in = LEN_I;
               end else if (reg_id == REG_SHORT6) begin
                  exp_len_in = LEN_S_6;
               end else if (reg_id == REG_SHORT4) begin
                  exp_len_in = LEN_S_4;
               end else begin
                  exp_len_in = LEN_S_LONG;
               end
            end
            OP_RX: begin
               if (busy_ff) begin
                  push          = 1'b1;
                  push_cmd.form = FORM_ECHO;
                  if (rx_count_ff == '0) begin
                     first_in = rx;
                  end
                  rx_count_in = cnt_next;
                  exp_len_in  = exp_eff;
                  sum_in      = sum_ff + rx;
                  if (cnt_next == 9'd2 && first_ff == NAK_FIRST && rx == NAK_SECOND) begin
                     push_cmd.has_done = 1'b1;
                     push_cmd.status   = ST_NAK;
                     busy_in           = 1'b0;
                  end else if (cnt_next >= exp_eff) begin
                     push_cmd.has_done = 1'b1;
                     push_cmd.status   = (chk == rx) ? ST_OK : ST_BAD_CHECK;
                     push_cmd.check    = chk;
                     busy_in           = 1'b0;
                  end
               end
            end
            OP_TICK: begin
               if (busy_ff) begin
                  ticks_in = ticks_next;
                  if (ticks_next >= timeout_ticks) begin
                     push              = 1'b1;
                     push_cmd.form     = FORM_DONE;
                     push_cmd.has_done = 1'b1;
                     push_cmd.status   = ST_TIMEOUT;
                     push_cmd.count    = rx_count_ff;
                     busy_in           = 1'b0;
                  end
               end
            end
            default: begin
               // unused code: drop
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rx_count_ff <= '0;
         exp_len_ff  <= '0;
         sum_ff      <= '0;
         first_ff    <= '0;
         ticks_ff    <= '0;
      end else begin
         busy_ff     <= busy_in;
         rx_count_ff <= rx_count_in;
         exp_len_ff  <= exp_len_in;
         sum_ff      <= sum_in;
         first_ff    <= first_in;
         ticks_ff    <= ticks_in;
      end
   end

endmodule

@@ src/rqle_fifo.sv @@
// ----------------------------------------------------------------------------
// rqle_fifo: command queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module rqle_fifo import rqle_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  cmd_type   push_cmd,
   input  logic      pop,
   output cmd_type   head,
   output qstat_type qstat
);

   cmd_type            entry_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff,  count_in;
   logic               do_push;
   logic               do_pop;

   assign qstat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign qstat.empty = (count_ff == '0);
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(do_push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ src/rqle_back.sv @@
// ----------------------------------------------------------------------------
// rqle_back: result generation
// Expands each queued command into its results, one per cycle unless the
// result port stalls, into an output register.
// ----------------------------------------------------------------------------
module rqle_back import rqle_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   head,
   input  qstat_type qstat,
   output logic      pop,
   output logic      rsp_tvalid,
   input  logic      rsp_tready,
   output rsp_type   rsp
);

   logic       valid_ff, valid_in;
   rsp_type    rsp_ff,   rsp_in;
   logic [1:0] step_ff,  step_in;
   logic [1:0] last_step;
   logic       load;
   rsp_type    cur;

   assign load       = !qstat.empty && (!valid_ff || rsp_tready);
   assign pop        = load && (step_ff == last_step);
   assign rsp_tvalid = valid_ff;
   assign rsp        = rsp_ff;

   // build the result at the current step
   always_comb begin
      cur       = '0;
      last_step = '0;
      case (head.form)
         FORM_QUERY: begin
            cur.kind       = KIND_TX;
            cur.byte_index = {7'd0, step_ff};
            if (head.mode_i) begin
               last_step = 2'd3;
               case (step_ff)
                  2'd0:    cur.data_byte = HDR_I;
                  2'd1:    cur.data_byte = CMD_I;
                  2'd2:    cur.data_byte = head.reg_id;
                  default: cur.data_byte = ~(HDR_I + CMD_I + head.reg_id);
               endcase
            end else begin
               last_step = 2'd2;
               case (step_ff)
                  2'd0:    cur.data_byte = HDR_S;
                  2'd1:    cur.data_byte = head.reg_id;
                  default: cur.data_byte = ~(HDR_S + head.reg_id);
               endcase
            end
         end
         FORM_ECHO: begin
            last_step = head.has_done ? 2'd1 : 2'd0;
            if (step_ff == 2'd0) begin
               cur.kind       = KIND_ECHO;
               cur.data_byte  = head.rx_byte;
               cur.byte_index = head.rx_index;
            end else begin
               cur.kind           = KIND_DONE;
               cur.status         = head.status;
               cur.received_count = head.count;
               cur.computed_check = head.check;
            end
         end
         default: begin
            cur.kind           = KIND_DONE;
            cur.status         = head.status;
            cur.received_count = head.count;
         end
      endcase
      cur.last = (step_ff == last_step);
   end

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      step_in  = step_ff;
      if (load) begin
         valid_in = 1'b1;
         rsp_in   = cur;
         step_in  = pop ? 2'd0 : step_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

endmodule

@@ src/register_query_link_engine.sv @@
// ----------------------------------------------------------------------------
// register_query_link_engine: serial link register query engine
// Sends query frames, echoes reply bytes and reports the end of each query.
// ----------------------------------------------------------------------------
// The request side takes one item per cycle whenever the four-entry command
// queue has room; the front end settles all query state (reply length, byte
// count, running sum, tick count) in that same cycle. The back end emits one
// result per cycle from an output register unless the result port stalls;
// a start yields 3 results in mode S and 4 in mode I, a received byte
// during a query 1 or 2, and a tick 0 or 1. The result port is what sets the
// sustained rate; the queue absorbs short bursts of starts and lets the request
// side run while results wait to be taken. No clearing pass follows reset.
module register_query_link_engine import rqle_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,   // operation
   input  logic [15:0]           req_tdata,   // register_id [7:0], rx_byte [15:8]
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,   // kind
   output logic                  rsp_tlast,
   // data_byte [7:0], byte_index [16:8], status [18:17],
   // received_count [27:19], computed_check [35:28], zero [39:36]
   output logic [39:0]           rsp_tdata,
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic        mode_ff,    mode_in;
   logic [15:0] timeout_ff, timeout_in;
   logic        csr_write;

   logic        push;
   cmd_type     push_cmd;
   logic        pop;
   cmd_type     head;
   qstat_type   qstat;
   rsp_type     rsp;

   // configuration registers: write on the access phase of a transfer
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      mode_in    = mode_ff;
      timeout_in = timeout_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_MODE:    mode_in    = csr_pwdata[0];
            REG_TIMEOUT: timeout_in = csr_pwdata[15:0];
            default:     mode_in    = mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MODE:    csr_prdata = {31'd0, mode_ff};
         REG_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         mode_ff    <= mode_in;
         timeout_ff <= timeout_in;
      end
   end

   // front end: take requests, advance query state, queue commands
   rqle_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .protocol_mode (mode_ff),
      .timeout_ticks (timeout_ff),
      .qstat         (qstat),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   // command queue between the two halves
   rqle_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .qstat    (qstat)
   );

   // back end: expand each command into result transfers
   rqle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;
   assign rsp_tdata = {4'd0, rsp.computed_check, rsp.received_count, rsp.status,
                       rsp.byte_index, rsp.data_byte};

`ifndef SYNTHESIS
   // a finish result always closes the results of its request
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DONE |-> rsp_tlast)
      else $error("finish result without last");

   // the back end never pops an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !qstat.empty)
      else $error("pop from empty command queue");

   // the queue can never be full and empty at once
   a_qstat_sane: assert property (@(posedge clock) disable iff (reset)
      !(qstat.full && qstat.empty))
      else $error("command queue both full and empty");

   // a transmit result carries no status, count or check
   a_tx_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TX |-> rsp_tdata[39:17] == '0)
      else $error("transmit result with finish fields set");
`endif

endmodule
